[design/assert_macros.svh]
// Assertion helper macros shared by the RTL.
// Expects clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/nfa_wm_pkg.sv]
// Shared types and constants of the NFA word membership block.
// No dependencies.
package nfa_wm_pkg;

	// Fixed field widths of the command channel
	localparam int CMD_W      = 3;
	localparam int STATE_FW   = 5;
	localparam int SYMBOL_FW  = 8;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_MARK  = 3'd2,
		CMD_START = 3'd3,
		CMD_FEED  = 3'd4,
		CMD_END   = 3'd5
	} cmd_t;

endpackage

[design/nfa_wm_if.sv]
// Channel interfaces of the NFA word membership block: commands, results, mode.
// Depends on nfa_wm_pkg for field widths.

// Command channel
interface nfa_wm_cmd_if
	import nfa_wm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [STATE_FW-1:0]  source_state;
	logic [SYMBOL_FW-1:0] symbol;
	logic [STATE_FW-1:0]  target_state;
	logic                 set_initial;
	logic                 set_final;

	modport source (output valid, command, source_state, symbol, target_state,
		set_initial, set_final, input ready);
	modport sink (input valid, command, source_state, symbol, target_state,
		set_initial, set_final, output ready);
endinterface

// Result channel
interface nfa_wm_res_if
	import nfa_wm_pkg::*;
();
	logic valid;
	logic ready;
	logic word_done;
	logic accepted;
	logic alive;

	modport source (output valid, word_done, accepted, alive, input ready);
	modport sink (input valid, word_done, accepted, alive, output ready);
endinterface

// Mode register write channel
interface nfa_wm_cfg_if
	import nfa_wm_pkg::*;
();
	logic valid;
	logic ready;
	logic prefix_mode;

	modport source (output valid, prefix_mode, input ready);
	modport sink (input valid, prefix_mode, output ready);
endinterface

[design/nfa_wm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nfa_wm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/nfa_word_membership_top.sv]
// Top level of the NFA word membership block.
// Depends on nfa_wm_pkg, the channel interfaces, nfa_wm_ram and assert_macros.svh.
//
// Usage:
//  cmd : one transaction per command (clear, add transition, mark state,
//        start word, feed symbol, end word). Each command yields exactly one
//        transaction on res (word_done, accepted, alive).
//  cfg : writes prefix_mode; always ready. Write only while the block is idle.
//  One command is worked on at a time; cmd.ready is high while idle.
//  Steps per command, accept to result valid:
//    add transition: read, merge, write back, result
//    feed symbol:    one transition row read per state
//                    from the transition RAM (one read port)
//    clear:          sweeping all NUM_STATES * 2**clog2(NUM_SYMBOLS) RAM rows,
//                    one row a cycle
//    other commands: straight to the result
//  After reset the same sweep runs with cmd.ready low; it gives no result.
//  Results sit in an output register; a new command is taken while a result
//  waits, and its own result is held back until res.ready frees the register.
`include "assert_macros.svh"

module nfa_word_membership_top
	import nfa_wm_pkg::*;
#(
	parameter int NUM_STATES  = 32,
	parameter int NUM_SYMBOLS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	nfa_wm_cmd_if.sink   cmd,
	nfa_wm_res_if.source res,
	nfa_wm_cfg_if.sink   cfg
);

	localparam int ST_W   = $clog2(NUM_STATES);
	localparam int SYM_W  = $clog2(NUM_SYMBOLS);
	localparam int ADDR_W = ST_W + SYM_W;
	localparam int DEPTH  = NUM_STATES * (2 ** SYM_W);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ADD_RD = 6'b000010,
		ST_ADD_WR = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_EMIT   = 6'b010000,
		ST_CLEAR  = 6'b100000
	} fsm_t;

	fsm_t                  state_q;
	logic [NUM_STATES-1:0] active_q;
	logic [NUM_STATES-1:0] initial_q;
	logic [NUM_STATES-1:0] final_q;
	logic                  prefix_hit_q;
	logic                  prefix_mode_q;
	logic                  emit_clr_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [ST_W-1:0]       rd_idx_q;
	logic                  issue_done_q;
	logic                  pend_s1;
	logic [NUM_STATES-1:0] next_q;

	// Latched command fields
	logic [ST_W-1:0]       src_q;
	logic [ST_W-1:0]       tgt_q;
	logic [SYM_W-1:0]      sym_q;
	logic                  r_done_q;
	logic                  r_acc_q;

	// Output register
	logic                  res_valid_q;
	logic                  res_done_q;
	logic                  res_acc_q;
	logic                  res_alive_q;

	// RAM port
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [NUM_STATES-1:0] mem_wdata;
	logic [ADDR_W-1:0]     mem_raddr;
	logic [NUM_STATES-1:0] mem_rdata;

	cmd_t                  cmd_code;
	logic                  cmd_fire;
	logic                  src_ok;
	logic                  tgt_ok;
	logic                  sym_ok;
	logic [ST_W-1:0]       src_idx;
	logic                  emit_go;
	logic [NUM_STATES-1:0] scan_sum;
	logic                  verdict;

	// Command decode and range checks
	assign cmd_code = cmd_t'(cmd.command);
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire = cmd.valid && cmd.ready;
	assign src_ok   = 32'(cmd.source_state) < 32'(NUM_STATES);
	assign tgt_ok   = 32'(cmd.target_state) < 32'(NUM_STATES);
	assign sym_ok   = 32'(cmd.symbol) < 32'(NUM_SYMBOLS);
	assign src_idx  = ST_W'(cmd.source_state);
	assign verdict  = (|(active_q & final_q)) || (prefix_mode_q && prefix_hit_q);

	// Accumulated successor set including the row arriving this cycle
	assign scan_sum = next_q | (pend_s1 ? mem_rdata : '0);

	assign emit_go = (state_q == ST_EMIT) && (!res_valid_q || res.ready);

	// Mode register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			prefix_mode_q <= cfg.prefix_mode;
		end
	end

	// Transition RAM port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_raddr = {src_q, sym_q};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_ADD_WR: begin
				mem_we    = 1'b1;
				mem_waddr = {src_q, sym_q};
				mem_wdata = mem_rdata | (NUM_STATES'(1) << tgt_q);
			end
			ST_SCAN: begin
				mem_raddr = {rd_idx_q, sym_q};
			end
			default: ;
		endcase
	end

	nfa_wm_ram #(
		.WIDTH (NUM_STATES),
		.DEPTH (DEPTH)
	) u_rows (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Command field capture and successor accumulation
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			src_q    <= src_idx;
			tgt_q    <= ST_W'(cmd.target_state);
			sym_q    <= SYM_W'(cmd.symbol);
			r_done_q <= (cmd_code == CMD_END);
			r_acc_q  <= (cmd_code == CMD_END) && verdict;
			next_q   <= '0;
		end else if (state_q == ST_SCAN) begin
			next_q <= scan_sum;
		end
	end

	// Control sequencer and automaton registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			emit_clr_q   <= 1'b0;
			active_q     <= '0;
			initial_q    <= '0;
			final_q      <= '0;
			prefix_hit_q <= 1'b0;
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			pend_s1      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						unique case (cmd_code)
							CMD_CLEAR: begin
								initial_q    <= '0;
								final_q      <= '0;
								active_q     <= '0;
								prefix_hit_q <= 1'b0;
								clr_q        <= '0;
								emit_clr_q   <= 1'b1;
								state_q      <= ST_CLEAR;
							end
							CMD_ADD: begin
								state_q <= (src_ok && tgt_ok && sym_ok) ? ST_ADD_RD : ST_EMIT;
							end
							CMD_MARK: begin
								if (src_ok && cmd.set_initial) begin
									initial_q[src_idx] <= 1'b1;
								end
								if (src_ok && cmd.set_final) begin
									final_q[src_idx] <= 1'b1;
								end
								state_q <= ST_EMIT;
							end
							CMD_START: begin
								active_q     <= initial_q;
								prefix_hit_q <= 1'b0;
								state_q      <= ST_EMIT;
							end
							CMD_FEED: begin
								if (|(active_q & final_q)) begin
									prefix_hit_q <= 1'b1;
								end
								if (sym_ok) begin
									rd_idx_q     <= '0;
									issue_done_q <= 1'b0;
									pend_s1      <= 1'b0;
									state_q      <= ST_SCAN;
								end else begin
									active_q <= '0;
									state_q  <= ST_EMIT;
								end
							end
							CMD_END: begin
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_ADD_RD: begin
					state_q <= ST_ADD_WR;
				end
				ST_ADD_WR: begin
					state_q <= ST_EMIT;
				end
				// One row read per state; each row is merged in the cycle after its read
				ST_SCAN: begin
					if (issue_done_q) begin
						active_q <= scan_sum;
						pend_s1  <= 1'b0;
						state_q  <= ST_EMIT;
					end else begin
						pend_s1 <= active_q[rd_idx_q];
						if (rd_idx_q == ST_W'(NUM_STATES - 1)) begin
							issue_done_q <= 1'b1;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (!res_valid_q || res.ready) begin
						state_q <= ST_IDLE;
					end
				end
				// Zero the transition RAM one row a cycle
				ST_CLEAR: begin
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						emit_clr_q <= 1'b0;
						state_q    <= emit_clr_q ? ST_EMIT : ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_done_q  <= r_done_q;
			res_acc_q   <= r_acc_q;
			res_alive_q <= |active_q;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.word_done = res_done_q;
	assign res.accepted  = res_acc_q;
	assign res.alive     = res_alive_q;

	// Checks
	`ASSERT_IMPL(a_ram_write_phase, mem_we, (state_q == ST_CLEAR) || (state_q == ST_ADD_WR), "RAM written outside clear sweep or add write-back")
	`ASSERT_NEXT(a_scan_finish, (state_q == ST_SCAN) && issue_done_q, state_q == ST_EMIT, "successor scan did not finish after last row")
	`ASSERT_NEXT(a_end_word_path, cmd_fire && (cmd_code == CMD_END), (state_q == ST_EMIT) && r_done_q, "end word did not go straight to result")

endmodule
